// ===== sv/stp_pkg.sv =====
// ============================================================================
// Stepper profile package
// Shared types and constants for the trapezoidal stepper profile driver.
// ============================================================================
package stp_pkg;

   localparam int DelayWidth = 17;
   localparam logic [DelayWidth-1:0] DelayMax = 17'h1FFFF;

   localparam logic [23:0] AccelReset = 24'd210000;
   localparam logic [15:0] VelocityReset = 16'd2450;

   localparam logic CsrAccel = 1'b0;
   localparam logic CsrVelocity = 1'b1;

   localparam logic OpTick = 1'b0;
   localparam logic OpStart = 1'b1;

   typedef struct packed {
      logic operation;
      logic signed [15:0] angle_deg;
   } req_word_type;

   typedef struct packed {
      logic [3:0] phase_pattern;
      logic step_event;
      logic busy_res;
      logic move_done;
      logic start_rejected;
      logic [DelayWidth-1:0] step_delay;
   } rsp_word_type;

   function automatic logic [3:0] coil_pattern(input logic [1:0] idx);
      logic [3:0] p;
      begin
         unique case (idx)
            2'd0: p = 4'h2;
            2'd1: p = 4'h8;
            2'd2: p = 4'h1;
            default: p = 4'h4;
         endcase
         return p;
      end
   endfunction

endpackage

// ===== sv/stp_divider.sv =====
// ============================================================================
// Serial divider
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module stp_divider #(
   parameter int NumWidth = 64,
   parameter int DenWidth = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] numerator,
   input  logic [DenWidth-1:0] denominator,
   output logic                done,
   output logic [NumWidth-1:0] quotient
);

   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] quot_ff, quot_in;
   logic [DenWidth:0] rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DenWidth:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DenWidth-1:0], quot_ff[NumWidth-1]};
      if (start) begin
         quot_in = numerator;
         rem_in = '0;
         den_in = denominator;
         cnt_in = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/stp_sqrt.sv =====
// ============================================================================
// Serial square root
// Digit-by-digit integer square root, one result bit per cycle.
// ============================================================================
module stp_sqrt #(
   parameter int InWidth = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [InWidth-1:0]    radicand,
   output logic                  done,
   output logic [InWidth/2-1:0]  root
);

   localparam int RootWidth = InWidth / 2;
   localparam int CntWidth = $clog2(RootWidth + 1);

   logic [InWidth-1:0] rad_ff, rad_in;
   logic [RootWidth+1:0] rem_ff, rem_in;
   logic [RootWidth-1:0] root_ff, root_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [RootWidth+1:0] shifted;
   logic [RootWidth+1:0] trial;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[RootWidth-1:0], rad_ff[InWidth-1:InWidth-2]};
      trial = {root_ff, 2'b01};
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = CntWidth'(RootWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[InWidth-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            root_in = {root_ff[RootWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            root_in = {root_ff[RootWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== sv/stepper_trapezoid_profile_driver.sv =====
// ============================================================================
// Stepper trapezoid profile driver
// Plans a trapezoidal or triangular velocity ramp and drives a full-step
// four-phase stepper one coil pattern per step.
// ============================================================================
// One word is taken at a time. A tick that does not end a step goes through
// the output state and is answered from the result register. A start that
// begins a move, and a tick that drives a new step, run a serial division and
// a square root. A tick that drives a step runs the one-bit-per-cycle divider,
// then the square root unit, with control states between them. A trapezoidal
// start adds a planning division first; a triangular start does not.
// A result word that waits on the result side holds off the next request.
module stepper_trapezoid_profile_driver #(
   parameter int TickRate = 100000,
   parameter int MaxRampSteps = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stp_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stp_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [23:0]           csr_data
);

   localparam logic [63:0] DelayNum = 64'(TickRate) * 64'(TickRate) * 64'd9;

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StPlanTri = 4'd1;
   localparam logic [3:0] StPlanDiv = 4'd2;
   localparam logic [3:0] StPlanWait = 4'd3;
   localparam logic [3:0] StStep = 4'd4;
   localparam logic [3:0] StDiv = 4'd5;
   localparam logic [3:0] StDivWait = 4'd6;
   localparam logic [3:0] StSqrt = 4'd7;
   localparam logic [3:0] StSqrtWait = 4'd8;
   localparam logic [3:0] StOut = 4'd9;
   localparam logic [3:0] StMulA = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [23:0] accel_ff, accel_in;
   logic [15:0] vel_ff, vel_in;
   logic [1:0] phase_ff, phase_in;
   logic last_dir_ff, last_dir_in;
   logic dir_ff, dir_in;
   logic moving_ff, moving_in;
   logic tri_ff, tri_in;
   logic [14:0] step_ff, step_in;
   logic [14:0] total_ff, total_in;
   logic [14:0] ramp_ff, ramp_in;
   logic [16:0] count_ff, count_in;
   logic [3:0] pattern_ff, pattern_in;
   logic [16:0] delay_ff, delay_in;
   logic [16:0] mag_ff, mag_in;
   logic [31:0] vv_ff, vv_in;
   logic [47:0] prod_ff, prod_in;
   logic [14:0] kidx_ff, kidx_in;
   logic ev_ff, ev_in;
   logic done_ff, done_in;
   logic rej_ff, rej_in;
   logic rsp_valid_ff, rsp_valid_in;
   stp_pkg::rsp_word_type rsp_ff, rsp_in;

   logic div_start;
   logic [63:0] div_num;
   logic [47:0] div_den;
   logic div_done;
   logic [63:0] div_quot;
   logic sq_start;
   logic sq_done;
   logic [31:0] sq_root;

   logic [23:0] a_eff;
   logic req_take;
   logic [16:0] raw_mag;
   logic [15:0] kk;
   logic [15:0] idx_raw;
   logic [1:0] idx_sel;
   logic [19:0] mag5;

   stp_divider #(.NumWidth(64), .DenWidth(48)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(div_den), .done(div_done), .quotient(div_quot)
   );

   stp_sqrt #(.InWidth(64)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(div_quot),
      .done(sq_done), .root(sq_root)
   );

   assign a_eff = (accel_ff == '0) ? 24'd1 : accel_ff;
   assign req_stall = (state_ff != StIdle) || (rsp_valid_ff && rsp_stall);
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign raw_mag = req_data.angle_deg[15] ? (17'h10000 - {1'b0, req_data.angle_deg})
                                           : {1'b0, req_data.angle_deg};
   assign mag5 = {3'b0, mag_ff} * 20'd5;

   always_comb begin
      idx_raw = {1'b0, step_ff};
      if (step_ff <= ramp_ff) begin
         idx_raw = {1'b0, step_ff};
      end else if (tri_ff) begin
         idx_raw = ({ramp_ff, 1'b1} > {1'b0, step_ff}) ?
                   ({ramp_ff, 1'b1} - {1'b0, step_ff}) : 16'd0;
      end else if ({1'b0, step_ff} + {1'b0, ramp_ff} <= {1'b0, total_ff}) begin
         idx_raw = {1'b0, ramp_ff};
      end else begin
         idx_raw = ({1'b0, total_ff} + 16'd1 > {1'b0, step_ff}) ?
                   ({1'b0, total_ff} + 16'd1 - {1'b0, step_ff}) : 16'd0;
      end
      if (idx_raw == '0) begin
         idx_raw = 16'd1;
      end
      kk = {1'b0, idx_raw[14:0]};
      if (kk > 16'(MaxRampSteps)) begin
         kk = 16'(MaxRampSteps);
      end
   end

   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      sq_start = 1'b0;
      if (state_ff == StPlanDiv) begin
         div_start = 1'b1;
         div_num = {32'b0, vv_ff} * 64'd5;
         div_den = 48'(a_eff) * 48'd18;
      end else if (state_ff == StDiv) begin
         div_start = 1'b1;
         div_num = DelayNum;
         div_den = 48'(a_eff) * 48'(kk) * 48'd10;
      end else if (state_ff == StSqrt) begin
         sq_start = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      accel_in = accel_ff;
      vel_in = vel_ff;
      phase_in = phase_ff;
      last_dir_in = last_dir_ff;
      dir_in = dir_ff;
      moving_in = moving_ff;
      tri_in = tri_ff;
      step_in = step_ff;
      total_in = total_ff;
      ramp_in = ramp_ff;
      count_in = count_ff;
      pattern_in = pattern_ff;
      delay_in = delay_ff;
      mag_in = mag_ff;
      vv_in = vv_ff;
      prod_in = prod_ff;
      kidx_in = kidx_ff;
      ev_in = ev_ff;
      done_in = done_ff;
      rej_in = rej_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      idx_sel = phase_ff;

      if (csr_valid) begin
         if (csr_index == stp_pkg::CsrAccel) begin
            accel_in = csr_data;
         end else begin
            vel_in = csr_data[15:0];
         end
      end

      unique case (state_ff)
         StIdle: begin
            if (req_take) begin
               ev_in = 1'b0;
               done_in = 1'b0;
               rej_in = 1'b0;
               if (req_data.operation == stp_pkg::OpStart) begin
                  if (moving_ff) begin
                     rej_in = 1'b1;
                     state_in = StOut;
                  end else begin
                     mag_in = raw_mag;
                     vv_in = 32'(vel_ff) * 32'(vel_ff);
                     dir_in = (req_data.angle_deg > 16'sd0) ? 1'b0 : 1'b1;
                     state_in = StMulA;
                  end
               end else if (moving_ff) begin
                  if (count_ff > 17'd1) begin
                     count_in = count_ff - 1'b1;
                     state_in = StOut;
                  end else begin
                     count_in = '0;
                     if (step_ff >= total_ff) begin
                        moving_in = 1'b0;
                        delay_in = '0;
                        done_in = 1'b1;
                        state_in = StOut;
                     end else begin
                        state_in = StStep;
                     end
                  end
               end else begin
                  state_in = StOut;
               end
            end
         end
         StMulA: begin
            prod_in = 48'(mag_ff) * 48'(a_eff);
            state_in = StPlanTri;
         end
         StPlanTri: begin
            total_in = 15'((36'(mag5) * 36'd7282) >> 16);
            if (20'(total_in) * 20'd9 > mag5) begin
               total_in = total_in - 1'b1;
            end
            step_in = '0;
            tri_in = prod_ff <= 48'(vv_ff);
            if (prod_ff <= 48'(vv_ff)) begin
               ramp_in = {1'b0, total_in[14:1]};
               if (total_in == '0) begin
                  done_in = 1'b1;
                  state_in = StOut;
               end else begin
                  moving_in = 1'b1;
                  state_in = StStep;
               end
            end else begin
               state_in = StPlanDiv;
            end
         end
         StPlanDiv: begin
            state_in = StPlanWait;
         end
         StPlanWait: begin
            if (div_done) begin
               ramp_in = (div_quot > 64'(MaxRampSteps)) ? 15'(MaxRampSteps)
                                                        : div_quot[14:0];
               if (total_ff == '0) begin
                  done_in = 1'b1;
                  state_in = StOut;
               end else begin
                  moving_in = 1'b1;
                  state_in = StStep;
               end
            end
         end
         StStep: begin
            step_in = step_ff + 1'b1;
            state_in = StDiv;
         end
         StDiv: begin
            kidx_in = kk[14:0];
            state_in = StDivWait;
         end
         StDivWait: begin
            if (div_done) begin
               state_in = StSqrt;
            end
         end
         StSqrt: begin
            state_in = StSqrtWait;
         end
         StSqrtWait: begin
            if (sq_done) begin
               if (sq_root == '0) begin
                  delay_in = 17'd1;
               end else if (sq_root > 32'(stp_pkg::DelayMax)) begin
                  delay_in = stp_pkg::DelayMax;
               end else begin
                  delay_in = sq_root[16:0];
               end
               count_in = delay_in;
               idx_sel = phase_ff;
               if (dir_ff != last_dir_ff) begin
                  idx_sel = dir_ff ? phase_ff - 2'd1 : phase_ff + 2'd1;
               end
               pattern_in = stp_pkg::coil_pattern(idx_sel);
               phase_in = dir_ff ? idx_sel - 2'd1 : idx_sel + 2'd1;
               last_dir_in = dir_ff;
               ev_in = 1'b1;
               state_in = StOut;
            end
         end
         StOut: begin
            rsp_valid_in = 1'b1;
            rsp_in.phase_pattern = pattern_ff;
            rsp_in.step_event = ev_ff;
            rsp_in.busy_res = moving_ff;
            rsp_in.move_done = done_ff;
            rsp_in.start_rejected = rej_ff;
            rsp_in.step_delay = moving_ff ? delay_ff : '0;
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         accel_ff <= stp_pkg::AccelReset;
         vel_ff <= stp_pkg::VelocityReset;
         phase_ff <= '0;
         last_dir_ff <= 1'b0;
         dir_ff <= 1'b0;
         moving_ff <= 1'b0;
         tri_ff <= 1'b0;
         step_ff <= '0;
         total_ff <= '0;
         ramp_ff <= '0;
         count_ff <= '0;
         pattern_ff <= '0;
         delay_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         accel_ff <= accel_in;
         vel_ff <= vel_in;
         phase_ff <= phase_in;
         last_dir_ff <= last_dir_in;
         dir_ff <= dir_in;
         moving_ff <= moving_in;
         tri_ff <= tri_in;
         step_ff <= step_in;
         total_ff <= total_in;
         ramp_ff <= ramp_in;
         count_ff <= count_in;
         pattern_ff <= pattern_in;
         delay_ff <= delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      vv_ff <= vv_in;
      prod_ff <= prod_in;
      kidx_ff <= kidx_in;
      ev_ff <= ev_in;
      done_ff <= done_in;
      rej_ff <= rej_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (step_ff <= total_ff))
      else $error("step number beyond move length");
   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.busy_res) |-> (rsp_ff.step_delay == '0))
      else $error("delay reported while idle");
   a_event_pattern: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.step_event) |-> $onehot(rsp_ff.phase_pattern))
      else $error("step without a single-coil pattern");
   a_ramp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDivWait) |-> (kidx_ff != '0))
      else $error("ramp index zero");

endmodule

// ===== tb/sv/stepper_trapezoid_profile_driver_tb.sv =====
// ============================================================================
// Stepper profile driver testbench
// Feeds start and tick words with random gaps and result back-pressure,
// predicts every result word from a cycle-free profile predictor and checks
// each one field by field, across several acceleration and velocity settings.
// ============================================================================
module stepper_trapezoid_profile_driver_tb;

   localparam int LimitCycles = 3000000;
   localparam int SettleCycles = 400;
   localparam longint unsigned TickRateSq9 = 64'd90000000000;
   localparam int RampMax = 255;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   stp_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   stp_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = stp_pkg::CsrAccel;
   logic [23:0] csr_data = '0;

   stp_pkg::req_word_type pending_words[$];
   stp_pkg::rsp_word_type expected_words[$];
   int idle_mode = 2;
   int mismatches = 0;
   int cycle_count = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int words_sent = 0;
   int starts_sent = 0;
   int steps_seen = 0;
   int moves_done = 0;

   // Predictor state.
   logic [23:0] accel_reg;
   logic [15:0] velocity_reg;
   logic [1:0] phase_idx;
   logic last_dir;
   logic move_dir;
   logic moving;
   logic tri_mode;
   int unsigned step_num;
   int unsigned steps_total;
   int unsigned ramp_steps;
   int unsigned tick_left;
   logic [3:0] pattern;
   logic [16:0] cur_delay;

   stepper_trapezoid_profile_driver u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      begin
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      end
   endfunction

   function automatic longint unsigned accel_used();
      return (accel_reg == 0) ? 64'd1 : 64'(accel_reg);
   endfunction

   function automatic logic [16:0] wait_ticks(input int unsigned k);
      longint unsigned kk;
      longint unsigned d;
      begin
         kk = (k < 1) ? 1 : k;
         if (kk > RampMax) kk = RampMax;
         d = root_floor(TickRateSq9 / (10 * accel_used() * kk));
         if (d < 1) d = 1;
         if (d > 131071) d = 131071;
         return 17'(d);
      end
   endfunction

   function automatic int unsigned ramp_position(input int unsigned i);
      int unsigned k;
      begin
         if (i <= ramp_steps) k = i;
         else if (tri_mode) k = (2 * ramp_steps + 1 > i) ? 2 * ramp_steps + 1 - i : 0;
         else if (i + ramp_steps <= steps_total) k = ramp_steps;
         else k = (steps_total + 1 > i) ? steps_total + 1 - i : 0;
         return (k < 1) ? 1 : k;
      end
   endfunction

   function automatic logic [1:0] coil_next(input logic [1:0] idx, input logic ccw);
      return ccw ? idx - 2'd1 : idx + 2'd1;
   endfunction

   task automatic take_step();
      logic [1:0] idx;
      begin
         idx = phase_idx;
         step_num = (step_num + 1) & 32'h7FFF;
         cur_delay = wait_ticks(ramp_position(step_num) & 32'h7FFF);
         tick_left = cur_delay;
         if (move_dir != last_dir) idx = coil_next(idx, move_dir);
         case (idx)
            2'd0: pattern = 4'h2;
            2'd1: pattern = 4'h8;
            2'd2: pattern = 4'h1;
            default: pattern = 4'h4;
         endcase
         phase_idx = coil_next(idx, move_dir);
         last_dir = move_dir;
      end
   endtask

   task automatic profile_reset();
      accel_reg = stp_pkg::AccelReset;
      velocity_reg = stp_pkg::VelocityReset;
      phase_idx = '0;
      last_dir = 1'b0;
      move_dir = 1'b0;
      moving = 1'b0;
      tri_mode = 1'b0;
      step_num = 0;
      steps_total = 0;
      ramp_steps = 0;
      tick_left = 0;
      pattern = '0;
      cur_delay = '0;
   endtask

   task automatic profile_accept(input stp_pkg::req_word_type w);
      stp_pkg::rsp_word_type r;
      longint unsigned mag;
      longint unsigned vv;
      longint unsigned acc;
      longint unsigned rr;
      begin
         r = '0;
         if (w.operation == stp_pkg::OpStart) begin
            if (moving) begin
               r.start_rejected = 1'b1;
            end else begin
               mag = (w.angle_deg < 0) ? 64'(-int'(w.angle_deg)) : 64'(w.angle_deg);
               vv = 64'(velocity_reg) * 64'(velocity_reg);
               acc = accel_used();
               move_dir = (w.angle_deg > 0) ? 1'b0 : 1'b1;
               steps_total = 32'(mag * 5 / 9);
               tri_mode = (mag * acc <= vv);
               if (tri_mode) begin
                  ramp_steps = 32'(mag * 5 / 18);
               end else begin
                  rr = vv * 5 / (18 * acc);
                  if (rr > RampMax) rr = RampMax;
                  ramp_steps = 32'(rr);
               end
               step_num = 0;
               if (steps_total == 0) begin
                  r.move_done = 1'b1;
               end else begin
                  moving = 1'b1;
                  take_step();
                  r.step_event = 1'b1;
               end
            end
         end else if (moving) begin
            if (tick_left > 1) begin
               tick_left = tick_left - 1;
            end else begin
               tick_left = 0;
               if (step_num >= steps_total) begin
                  moving = 1'b0;
                  cur_delay = '0;
                  r.move_done = 1'b1;
               end else begin
                  take_step();
                  r.step_event = 1'b1;
               end
            end
         end
         r.phase_pattern = pattern;
         r.busy_res = moving;
         r.step_delay = moving ? cur_delay : '0;
         expected_words.push_back(r);
      end
   endtask

   // Sender side.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            profile_accept(req_data);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 37) &&
                !(idle_mode == 1 && $urandom_range(99) < 48)) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver side.
   always @(posedge clock) begin
      stp_pkg::rsp_word_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result word %h", rsp_data);
            end else begin
               e = expected_words.pop_front();
               if (rsp_data.step_event) steps_seen <= steps_seen + 1;
               if (rsp_data.move_done) moves_done <= moves_done + 1;
               if (rsp_data.phase_pattern !== e.phase_pattern ||
                   rsp_data.step_event !== e.step_event ||
                   rsp_data.busy_res !== e.busy_res ||
                   rsp_data.move_done !== e.move_done ||
                   rsp_data.start_rejected !== e.start_rejected ||
                   rsp_data.step_delay !== e.step_delay) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("result word mismatch: expected %h actual %h", e, rsp_data);
               end
            end
         end
         if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= 600;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (idle_mode == 0 && $urandom_range(99) < 48) ||
                         (idle_mode == 1 && $urandom_range(99) < 37);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("stepper_trapezoid_profile_driver: mismatch");
         $finish;
      end
   end

   task automatic write_reg(input logic idx, input logic [23:0] value);
      begin
         csr_index <= idx;
         csr_data <= value;
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         csr_valid <= 1'b0;
         if (idx == stp_pkg::CsrAccel) accel_reg = value;
         else velocity_reg = value[15:0];
      end
   endtask

   task automatic queue_word(input logic op, input logic signed [15:0] ang);
      stp_pkg::req_word_type w;
      begin
         w.operation = op;
         w.angle_deg = ang;
         pending_words.push_back(w);
         if (op == stp_pkg::OpStart) starts_sent++;
      end
   endtask

   task automatic queue_random(input int count);
      int n;
      begin
         for (n = 0; n < count; n++) begin
            case ($urandom_range(9))
               0: queue_word(stp_pkg::OpStart, 16'($urandom_range(65535)));
               1, 2: queue_word(stp_pkg::OpStart, 16'(int'($urandom_range(40)) - 20));
               default: queue_word(stp_pkg::OpTick, 16'($urandom_range(65535)));
            endcase
         end
      end
   endtask

   task automatic drain();
      begin
         while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
            @(posedge clock);
         repeat (SettleCycles) @(posedge clock);
      end
   endtask

   initial begin
      int n;
      profile_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, directed words first.
      idle_mode = 0;
      queue_word(stp_pkg::OpTick, 16'sd0);
      queue_word(stp_pkg::OpStart, 16'sd0);
      queue_word(stp_pkg::OpStart, 16'sd1);
      queue_word(stp_pkg::OpStart, 16'sd2);
      queue_word(stp_pkg::OpStart, 16'sd5);
      for (n = 0; n < 4; n++) queue_word(stp_pkg::OpTick, 16'h7FFF);
      queue_word(stp_pkg::OpStart, -16'sd3);
      queue_word(stp_pkg::OpStart, 16'h8000);
      queue_word(stp_pkg::OpStart, 16'h7FFF);
      queue_word(stp_pkg::OpStart, -16'sd1);
      for (n = 0; n < 6; n++) queue_word(stp_pkg::OpTick, 16'h8000);
      queue_random(110);
      drain();

      write_reg(stp_pkg::CsrAccel, 24'hFFFFFF);
      write_reg(stp_pkg::CsrVelocity, 24'd65535);
      idle_mode = 1;
      for (n = 0; n < 4; n++) queue_word(stp_pkg::OpTick, 16'sd0);
      queue_word(stp_pkg::OpStart, 16'sd2);
      for (n = 0; n < 30; n++) queue_word(stp_pkg::OpTick, 16'sd0);
      queue_word(stp_pkg::OpStart, -16'sd2);
      for (n = 0; n < 30; n++) queue_word(stp_pkg::OpTick, 16'sd0);
      queue_random(100);
      drain();

      write_reg(stp_pkg::CsrVelocity, 24'd1);
      idle_mode = 2;
      queue_random(150);
      @(negedge clock);
      hold_token = hold_token + 1;
      drain();

      write_reg(stp_pkg::CsrAccel, 24'd1);
      write_reg(stp_pkg::CsrVelocity, 24'd65535);
      queue_word(stp_pkg::OpStart, 16'sd9);
      queue_random(60);
      drain();

      write_reg(stp_pkg::CsrAccel, 24'd210000);
      write_reg(stp_pkg::CsrVelocity, 24'd2450);
      idle_mode = 0;
      queue_random(60);
      drain();

      $display("covered %0d words, %0d starts, %0d steps, %0d finished moves",
               words_sent, starts_sent, steps_seen, moves_done);
      $display("settings ranged over acceleration 1 to 16777215, velocity 1 to 65535");
      if (mismatches == 0) begin
         $display("stepper_trapezoid_profile_driver: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("stepper_trapezoid_profile_driver: mismatch");
      end
      $finish;
   end

endmodule
